// ----- rtl/core/lpvf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpvf_pkg
// Shared types and constants of the lidar point validity filter.
// ----------------------------------------------------------------------------
package lpvf_pkg;

    localparam int LINE_CNT_W = 7;
    localparam int DEC_W      = 8;
    localparam int BLIND_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TAG_W      = 8;
    localparam int LINE_W     = 8;
    localparam int REFL_W     = 8;
    localparam int TIME_W     = 32;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_COUNT = 2'd0,
        CFG_DECIMATION = 2'd1,
        CFG_BLIND_MM   = 2'd2
    } cfg_idx_t;

    localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RST = 7'd6;
    localparam logic [DEC_W-1:0]      DECIMATION_RST = 8'd1;
    localparam logic [BLIND_W-1:0]    BLIND_MM_RST   = 16'd10;
    localparam logic [SQ_W-1:0]       BLIND_SQ_RST   = 32'd100;

    // return class in tag bits 5:4
    localparam logic [TAG_W-1:0] TAG_RET_MASK   = 8'h30;
    localparam logic [TAG_W-1:0] TAG_RET_FIRST  = 8'h00;
    localparam logic [TAG_W-1:0] TAG_RET_SECOND = 8'h10;

    typedef struct packed {
        logic [LINE_CNT_W-1:0] line_count;
        logic [DEC_W-1:0]      decimation;
        logic [BLIND_W-1:0]    blind_mm;
    } cfg_t;

    typedef struct packed {
        logic [REFL_W-1:0] intensity;
        logic [TIME_W-1:0] time_ns;
    } attr_t;

endpackage

// ----- rtl/core/lpvf_in_if.sv -----
// ----------------------------------------------------------------------------
// lpvf_in_if
// Input point channel: valid/ready handshake with one raw lidar point.
// ----------------------------------------------------------------------------
interface lpvf_in_if
    import lpvf_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         frame_start;
    logic signed [COORD_BITS-1:0] x_mm;
    logic signed [COORD_BITS-1:0] y_mm;
    logic signed [COORD_BITS-1:0] z_mm;
    logic [REFL_W-1:0]            reflectivity;
    logic [TAG_W-1:0]             tag;
    logic [LINE_W-1:0]            line;
    logic [TIME_W-1:0]            offset_ns;

    modport source (
        output valid, frame_start, x_mm, y_mm, z_mm, reflectivity, tag, line, offset_ns,
        input  ready
    );

    modport sink (
        input  valid, frame_start, x_mm, y_mm, z_mm, reflectivity, tag, line, offset_ns,
        output ready
    );
endinterface

// ----- rtl/core/lpvf_out_if.sv -----
// ----------------------------------------------------------------------------
// lpvf_out_if
// Output point channel: valid/ready handshake with one accepted point.
// ----------------------------------------------------------------------------
interface lpvf_out_if
    import lpvf_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x_mm;
    logic signed [COORD_BITS-1:0] out_y_mm;
    logic signed [COORD_BITS-1:0] out_z_mm;
    logic [REFL_W-1:0]            intensity;
    logic [TIME_W-1:0]            time_ns;

    modport source (
        output valid, out_x_mm, out_y_mm, out_z_mm, intensity, time_ns,
        input  ready
    );

    modport sink (
        input  valid, out_x_mm, out_y_mm, out_z_mm, intensity, time_ns,
        output ready
    );
endinterface

// ----- rtl/core/lidar_point_validity_filter.sv -----
// Path: an accepted point moves through the gate holding register, then the
// magnitude, square and output registers, before its output transfer.
// Throughput: one point per cycle; the gate holding register, magnitude,
// square and output registers each stall only when the stage after is full.
// Reset: rst_n clears the frame phase, previous point and all valid bits, and
// loads line_count 6, decimation 1, blind_mm 10; it takes effect at once.
// ----------------------------------------------------------------------------
// lidar_point_validity_filter
// Lidar point filter: line, tag and decimation checks, duplicate removal and
// blind radius rejection, with a plain configuration write port.
// ----------------------------------------------------------------------------
module lidar_point_validity_filter
    import lpvf_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    lpvf_in_if.sink               pts_in,
    lpvf_out_if.source            pts_out
);

    cfg_t                         cfg_reg;
    logic                         a_valid;
    logic                         a_ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    attr_t                        a_attr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_count <= LINE_COUNT_RST;
            cfg_reg.decimation <= DECIMATION_RST;
            cfg_reg.blind_mm   <= BLIND_MM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LINE_COUNT: cfg_reg.line_count <= cfg_wdata[LINE_CNT_W-1:0];
                CFG_DECIMATION: cfg_reg.decimation <= cfg_wdata[DEC_W-1:0];
                CFG_BLIND_MM:   cfg_reg.blind_mm   <= cfg_wdata[BLIND_W-1:0];
                default:        ;
            endcase
        end
    end

    lpvf_gate #(
        .COORD_BITS (COORD_BITS)
    ) u_gate (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .pts_in  (pts_in),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_x     (a_x),
        .a_y     (a_y),
        .a_z     (a_z),
        .a_attr  (a_attr)
    );

    lpvf_blind #(
        .COORD_BITS (COORD_BITS)
    ) u_blind (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_x     (a_x),
        .a_y     (a_y),
        .a_z     (a_z),
        .a_attr  (a_attr),
        .pts_out (pts_out)
    );

endmodule

// ----- rtl/core/lpvf_gate.sv -----
// ----------------------------------------------------------------------------
// lpvf_gate
// Per-point acceptance: frame phase, line/tag/decimation checks, previous
// point tracking and duplicate removal. Survivors go to a holding register.
// ----------------------------------------------------------------------------
module lpvf_gate
    import lpvf_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    lpvf_in_if.sink                      pts_in,
    output logic                         a_valid,
    input  logic                         a_ready,
    output logic signed [COORD_BITS-1:0] a_x,
    output logic signed [COORD_BITS-1:0] a_y,
    output logic signed [COORD_BITS-1:0] a_z,
    output attr_t                        a_attr
);

    logic [DEC_W-1:0]             phase_reg;
    logic [DEC_W-1:0]             phase_next;
    logic [DEC_W-1:0]             phase_cur;
    logic [DEC_W-1:0]             phase_inc;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] prev_z_reg;
    logic                         a_valid_reg;
    logic                         a_valid_next;
    logic signed [COORD_BITS-1:0] a_x_reg;
    logic signed [COORD_BITS-1:0] a_y_reg;
    logic signed [COORD_BITS-1:0] a_z_reg;
    attr_t                        a_attr_reg;
    logic                         accept;
    logic                         line_ok;
    logic                         tag_ok;
    logic                         keep;
    logic                         differs;

    assign pts_in.ready = !a_valid_reg || a_ready;
    assign accept       = pts_in.valid && pts_in.ready;

    always_comb
    begin
        phase_cur = pts_in.frame_start ? '0 : phase_reg;
        phase_inc = phase_cur + DEC_W'(1);
        // decimation of zero lands here too and acts like one
        phase_next = (phase_inc >= cfg.decimation) ? '0 : phase_inc;

        line_ok = pts_in.line < {1'b0, cfg.line_count};
        tag_ok  = ((pts_in.tag & TAG_RET_MASK) == TAG_RET_FIRST)
               || ((pts_in.tag & TAG_RET_MASK) == TAG_RET_SECOND);
        keep    = !pts_in.frame_start && line_ok && tag_ok && (phase_cur == '0);
        differs = (pts_in.x_mm != prev_x_reg) || (pts_in.y_mm != prev_y_reg)
               || (pts_in.z_mm != prev_z_reg);

        if (accept)
        begin
            a_valid_next = keep && differs;
        end
        else if (a_ready)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_z_reg  <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                if (keep)
                begin
                    prev_x_reg <= pts_in.x_mm;
                    prev_y_reg <= pts_in.y_mm;
                    prev_z_reg <= pts_in.z_mm;
                end
                else
                begin
                    prev_x_reg <= '0;
                    prev_y_reg <= '0;
                    prev_z_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg              <= pts_in.x_mm;
            a_y_reg              <= pts_in.y_mm;
            a_z_reg              <= pts_in.z_mm;
            a_attr_reg.intensity <= pts_in.reflectivity;
            a_attr_reg.time_ns   <= pts_in.offset_ns;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_x     = a_x_reg;
    assign a_y     = a_y_reg;
    assign a_z     = a_z_reg;
    assign a_attr  = a_attr_reg;

`ifndef ASSERT_OFF
    // a frame start restarts the phase: the next index is 1 modulo decimation
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pts_in.frame_start) |=>
            (phase_reg == (($past(cfg.decimation) <= DEC_W'(1)) ? '0 : DEC_W'(1))))
        else $error("lpvf_gate: phase not restarted by frame start");

    // a rejected point clears the stored previous point
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !keep) |=> (prev_x_reg == '0 && prev_y_reg == '0 && prev_z_reg == '0))
        else $error("lpvf_gate: previous point not cleared on reject");

    // a held point stays put until the blind stage takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_ready) |=>
            (a_valid_reg && $stable(a_x_reg) && $stable(a_attr_reg)))
        else $error("lpvf_gate: held point changed while stalled");
`endif

endmodule

// ----- rtl/core/lpvf_blind.sv -----
// ----------------------------------------------------------------------------
// lpvf_blind
// Blind zone check: magnitudes, squares, sum against radius squared, and the
// output register.
// ----------------------------------------------------------------------------
module lpvf_blind
    import lpvf_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         a_valid,
    output logic                         a_ready,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  attr_t                        a_attr,
    lpvf_out_if.source                   pts_out
);

    function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] m;
        m = v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
        return m;
    endfunction

    logic [COORD_BITS-1:0]        mag_x;
    logic [COORD_BITS-1:0]        mag_y;
    logic [COORD_BITS-1:0]        mag_z;
    logic                         big;

    logic [SQ_W-1:0]              blind_sq_reg;

    logic                         b_valid_reg;
    logic                         b_ready;
    logic [MAG_W-1:0]             b_mx_reg;
    logic [MAG_W-1:0]             b_my_reg;
    logic [MAG_W-1:0]             b_mz_reg;
    logic                         b_big_reg;
    logic signed [COORD_BITS-1:0] b_x_reg;
    logic signed [COORD_BITS-1:0] b_y_reg;
    logic signed [COORD_BITS-1:0] b_z_reg;
    attr_t                        b_attr_reg;

    logic                         c_valid_reg;
    logic                         c_ready;
    logic [SQ_W-1:0]              c_sx_reg;
    logic [SQ_W-1:0]              c_sy_reg;
    logic [SQ_W-1:0]              c_sz_reg;
    logic                         c_big_reg;
    logic signed [COORD_BITS-1:0] c_x_reg;
    logic signed [COORD_BITS-1:0] c_y_reg;
    logic signed [COORD_BITS-1:0] c_z_reg;
    attr_t                        c_attr_reg;

    logic                         o_valid_reg;
    logic                         o_ready;
    logic signed [COORD_BITS-1:0] o_x_reg;
    logic signed [COORD_BITS-1:0] o_y_reg;
    logic signed [COORD_BITS-1:0] o_z_reg;
    attr_t                        o_attr_reg;

    logic [SUM_W-1:0]             sq_sum;
    logic                         in_zone;

    assign mag_x = mag(a_x);
    assign mag_y = mag(a_y);
    assign mag_z = mag(a_z);

    // any magnitude of 65536 or more is always outside the radius
    generate
        if (COORD_BITS > MAG_W)
        begin : g_big
            assign big = (|mag_x[COORD_BITS-1:MAG_W]) || (|mag_y[COORD_BITS-1:MAG_W])
                      || (|mag_z[COORD_BITS-1:MAG_W]);
        end
        else
        begin : g_no_big
            assign big = 1'b0;
        end
    endgenerate

    assign o_ready = !o_valid_reg || pts_out.ready;
    assign c_ready = !c_valid_reg || o_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = b_ready;

    assign sq_sum  = {2'b00, c_sx_reg} + {2'b00, c_sy_reg} + {2'b00, c_sz_reg};
    assign in_zone = !c_big_reg && (sq_sum < {2'b00, blind_sq_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blind_sq_reg <= BLIND_SQ_RST;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            blind_sq_reg <= cfg.blind_mm * cfg.blind_mm;
            if (b_ready)
            begin
                b_valid_reg <= a_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= c_valid_reg && !in_zone;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_mx_reg   <= mag_x[MAG_W-1:0];
            b_my_reg   <= mag_y[MAG_W-1:0];
            b_mz_reg   <= mag_z[MAG_W-1:0];
            b_big_reg  <= big;
            b_x_reg    <= a_x;
            b_y_reg    <= a_y;
            b_z_reg    <= a_z;
            b_attr_reg <= a_attr;
        end
        if (c_ready)
        begin
            c_sx_reg   <= b_mx_reg * b_mx_reg;
            c_sy_reg   <= b_my_reg * b_my_reg;
            c_sz_reg   <= b_mz_reg * b_mz_reg;
            c_big_reg  <= b_big_reg;
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            c_z_reg    <= b_z_reg;
            c_attr_reg <= b_attr_reg;
        end
        if (o_ready)
        begin
            o_x_reg    <= c_x_reg;
            o_y_reg    <= c_y_reg;
            o_z_reg    <= c_z_reg;
            o_attr_reg <= c_attr_reg;
        end
    end

    assign pts_out.valid     = o_valid_reg;
    assign pts_out.out_x_mm  = o_x_reg;
    assign pts_out.out_y_mm  = o_y_reg;
    assign pts_out.out_z_mm  = o_z_reg;
    assign pts_out.intensity = o_attr_reg.intensity;
    assign pts_out.time_ns   = o_attr_reg.time_ns;

`ifndef ASSERT_OFF
    // a point inside the blind zone never reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_ready && in_zone) |=> !o_valid_reg)
        else $error("lpvf_blind: blind-zone point emitted");

    // a point outside the zone is presented with its own coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_ready && !in_zone) |=>
            (o_valid_reg && pts_out.out_x_mm == $past(c_x_reg)
             && pts_out.out_z_mm == $past(c_z_reg)))
        else $error("lpvf_blind: accepted point lost or altered");

    // a stalled output point holds steady until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (pts_out.valid && !pts_out.ready) |=>
            (pts_out.valid && $stable(pts_out.out_x_mm) && $stable(pts_out.time_ns)))
        else $error("lpvf_blind: output changed while stalled");
`endif

endmodule
